[hdl/lmss_pkg.sv]
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types, constants and pattern tables for the scrolling LED matrix
// scanner.
// ----------------------------------------------------------------------------
package lmss_pkg;

   localparam int GLYPH_SLOTS = 64;
   localparam int MATRIX_SIZE = 8;

   localparam int COL_W      = $clog2(MATRIX_SIZE);
   localparam int ROW_W      = MATRIX_SIZE;
   localparam int SHIFT_W    = $clog2(ROW_W + 1);
   localparam int RAM_DEPTH  = GLYPH_SLOTS * MATRIX_SIZE;
   localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);
   localparam int TEXT_LAST  = 2 * MATRIX_SIZE;
   localparam int ROT_LAST   = MATRIX_SIZE - 1;
   localparam int STEP_W     = $clog2(TEXT_LAST + 1);

   localparam int SLOT_W     = 6;
   // text slot plus one, compared against a slot count of up to 256
   localparam int SLOT_CMP_W = 9;
   localparam int COUNT_W    = 6;
   localparam int PERIOD_W   = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0]  RESET_CHAR_COUNT = 6'd5;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD     = 16'd500;

   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_PERIOD = 2'd2;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_TEXT  = 2'd0,
      MODE_UP    = 2'd1,
      MODE_DOWN  = 2'd2,
      MODE_SMILE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TEXT,
      ST_ROT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_TEXT,
      JOB_ROT
   } job_type;

   typedef struct packed {
      logic                  ready;
      logic                  clear_en;
      logic [RAM_ADDR_W-1:0] clear_addr;
      logic                  text_en;
      logic                  rot_en;
      logic                  last;
      logic                  finish;
      logic [STEP_W-1:0]     step;
   } seq_ctl_type;

   function automatic logic [ROW_W-1:0] up_arrow(input logic [COL_W-1:0] idx);
      logic [ROW_W-1:0] v;
      case (idx)
         3'd0, 3'd7: v = 8'b00011000;
         3'd1, 3'd6: v = 8'b00110000;
         3'd2, 3'd5: v = 8'b01100000;
         3'd3, 3'd4: v = 8'b11100000;
         default:    v = 8'b00000000;
      endcase
      return v;
   endfunction

   function automatic logic [ROW_W-1:0] down_arrow(input logic [COL_W-1:0] idx);
      logic [ROW_W-1:0] v;
      case (idx)
         3'd0, 3'd7: v = 8'b00011000;
         3'd1, 3'd6: v = 8'b00001100;
         3'd2, 3'd5: v = 8'b00000110;
         3'd3, 3'd4: v = 8'b00000011;
         default:    v = 8'b00000000;
      endcase
      return v;
   endfunction

   function automatic logic [ROW_W-1:0] smile_face(input logic [COL_W-1:0] idx);
      logic [ROW_W-1:0] v;
      case (idx)
         3'd1, 3'd6: v = 8'b00100000;
         3'd2, 3'd5: v = 8'b01000100;
         3'd3, 3'd4: v = 8'b00100010;
         default:    v = 8'b00000000;
      endcase
      return v;
   endfunction

endpackage

[hdl/lmss_ram.sv]
// ----------------------------------------------------------------------------
// lmss_ram
// Generic single-port RAM, one access a cycle, registered read; a write also reads the old word.
// ----------------------------------------------------------------------------
module lmss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/lmss_shifter.sv]
// ----------------------------------------------------------------------------
// lmss_shifter
// Shared funnel shifter: takes the low row of a two-row word shifted right.
// Serves both the text scroll blend and the arrow rotations.
// ----------------------------------------------------------------------------
module lmss_shifter (
   input  logic [2*lmss_pkg::ROW_W-1:0]  din,
   input  logic [lmss_pkg::SHIFT_W-1:0]  amount,
   output logic [lmss_pkg::ROW_W-1:0]    dout
);

   logic [2*lmss_pkg::ROW_W-1:0] shifted;

   assign shifted = din >> amount;
   assign dout    = shifted[lmss_pkg::ROW_W-1:0];

endmodule

[hdl/lmss_sequencer.sv]
// ----------------------------------------------------------------------------
// lmss_sequencer
// Control state machine: store clearing sweep, request intake, step counter
// for the frame update passes and the hand-off to the result register.
// ----------------------------------------------------------------------------
module lmss_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lmss_pkg::job_type     start_job,
   input  logic                  rsp_free,
   output lmss_pkg::seq_ctl_type ctl
);

   lmss_pkg::state_type                state_ff, state_in;
   logic [lmss_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [lmss_pkg::RAM_ADDR_W-1:0]    clr_ff, clr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmss_pkg::ST_CLEAR;
         step_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      clr_in         = clr_ff;
      ctl            = '0;
      ctl.step       = step_ff;
      ctl.clear_addr = clr_ff;
      case (state_ff)
         lmss_pkg::ST_CLEAR: begin
            ctl.clear_en = 1'b1;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == lmss_pkg::RAM_ADDR_W'(lmss_pkg::RAM_DEPTH - 1)) begin
               state_in = lmss_pkg::ST_IDLE;
            end
         end
         lmss_pkg::ST_IDLE: begin
            ctl.ready = 1'b1;
            if (start) begin
               step_in = '0;
               case (start_job)
                  lmss_pkg::JOB_TEXT: state_in = lmss_pkg::ST_TEXT;
                  lmss_pkg::JOB_ROT:  state_in = lmss_pkg::ST_ROT;
                  default:            state_in = lmss_pkg::ST_DONE;
               endcase
            end
         end
         lmss_pkg::ST_TEXT: begin
            ctl.text_en = 1'b1;
            step_in     = step_ff + 1'b1;
            if (step_ff == lmss_pkg::STEP_W'(lmss_pkg::TEXT_LAST)) begin
               ctl.last = 1'b1;
               state_in = lmss_pkg::ST_DONE;
            end
         end
         lmss_pkg::ST_ROT: begin
            ctl.rot_en = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == lmss_pkg::STEP_W'(lmss_pkg::ROT_LAST)) begin
               ctl.last = 1'b1;
               state_in = lmss_pkg::ST_DONE;
            end
         end
         lmss_pkg::ST_DONE: begin
            if (rsp_free) begin
               ctl.finish = 1'b1;
               state_in   = lmss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lmss_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/led_matrix_scroll_scanner.sv]
// ----------------------------------------------------------------------------
// led_matrix_scroll_scanner
// Column-multiplexed 8x8 LED matrix driver with text scroll, rotating arrows
// and a static smile, fed by tick and glyph column write requests.
// ----------------------------------------------------------------------------
//  channel  direction  ports                                    handshake
//  req      in         func, glyph_slot, glyph_column, glyph_bits  req_valid/req_ready
//  rsp      out        column_drive, row_drive, frame_updated      rsp_valid/rsp_ready
//  csr      in         index, data                                 csr_valid/csr_ready
//
//  a glyph write or a tick without frame update goes from accept straight to
//  the final step, which loads the result register; an arrow update first
//  rewrites the frame columns through the shared funnel shifter, a text update
//  pairs single-port glyph store reads through it; the next request is taken
//  once the block is back in idle. after reset a clearing pass zeroes the
//  glyph store with req_ready low; csr writes are taken at all times.
//  a request is taken while the previous result still waits in the output
//  register; a stalled result holds the block in its final step.
// ----------------------------------------------------------------------------
module led_matrix_scroll_scanner (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [lmss_pkg::SLOT_W-1:0]       req_glyph_slot,
   input  logic [lmss_pkg::COL_W-1:0]        req_glyph_column,
   input  logic [lmss_pkg::ROW_W-1:0]        req_glyph_bits,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lmss_pkg::ROW_W-1:0]        rsp_column_drive,
   output logic [lmss_pkg::ROW_W-1:0]        rsp_row_drive,
   output logic                              rsp_frame_updated,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lmss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lmss_pkg::CSR_DATA_W-1:0]   csr_data
);

   // configuration
   lmss_pkg::mode_type                 display_mode_ff;
   logic [lmss_pkg::COUNT_W-1:0]       char_count_ff;
   logic [lmss_pkg::PERIOD_W-1:0]      scroll_period_ff;

   // display state
   logic [lmss_pkg::ROW_W-1:0]         frame_ff [lmss_pkg::MATRIX_SIZE];
   logic [lmss_pkg::PERIOD_W-1:0]      tick_count_ff;
   logic [lmss_pkg::COL_W-1:0]         scan_ff;
   logic [lmss_pkg::COL_W-1:0]         text_shift_ff;
   logic [lmss_pkg::SLOT_W-1:0]        text_slot_ff;
   logic [lmss_pkg::COL_W-1:0]         up_shift_ff;
   logic [lmss_pkg::COL_W-1:0]         down_shift_ff;

   // request in flight
   logic                               is_write_ff;
   logic                               upd_ff;

   // text pass datapath
   logic [lmss_pkg::ROW_W-1:0]         a_ff;
   logic                               blank_ff;

   // result register
   logic                               rsp_valid_ff;
   logic [lmss_pkg::ROW_W-1:0]         col_drive_ff;
   logic [lmss_pkg::ROW_W-1:0]         row_drive_ff;
   logic                               frame_upd_ff;

   lmss_pkg::seq_ctl_type              ctl;
   lmss_pkg::job_type                  job;
   logic                               accept;
   logic                               rsp_free;
   logic [lmss_pkg::PERIOD_W-1:0]      tick_sum;
   logic                               period_hit;
   logic                               do_update;

   logic                               ram_we;
   logic [lmss_pkg::RAM_ADDR_W-1:0]    ram_addr;
   logic [lmss_pkg::ROW_W-1:0]         ram_wdata;
   logic [lmss_pkg::ROW_W-1:0]         ram_rdata;
   logic [lmss_pkg::ROW_W-1:0]         rd_val;
   logic                               wr_slot_ok;
   logic [lmss_pkg::SLOT_W:0]          rd_slot;
   logic                               rd_slot_ok;

   logic [2*lmss_pkg::ROW_W-1:0]       sh_din;
   logic [lmss_pkg::SHIFT_W-1:0]       sh_amount;
   logic [lmss_pkg::ROW_W-1:0]         sh_dout;
   logic [lmss_pkg::ROW_W-1:0]         arrow_col;
   logic [lmss_pkg::COL_W-1:0]         text_col;
   logic [lmss_pkg::SLOT_W:0]          slot_inc;
   logic                               slot_wrap;

   logic [lmss_pkg::ROW_W-1:0]         rows_now;
   logic [lmss_pkg::ROW_W-1:0]         drive_now;

   assign accept    = req_valid && req_ready;
   assign req_ready = ctl.ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign tick_sum   = tick_count_ff + 1'b1;
   assign period_hit = tick_sum >= scroll_period_ff;
   assign do_update  = period_hit && (display_mode_ff != lmss_pkg::MODE_SMILE);

   always_comb begin
      job = lmss_pkg::JOB_NONE;
      if (req_func == lmss_pkg::FUNC_TICK && do_update) begin
         job = (display_mode_ff == lmss_pkg::MODE_TEXT) ? lmss_pkg::JOB_TEXT
                                                        : lmss_pkg::JOB_ROT;
      end
   end

   lmss_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .start_job (job),
      .rsp_free  (rsp_free),
      .ctl       (ctl)
   );

   // glyph store port: clearing sweep, text reads or request writes
   assign wr_slot_ok = lmss_pkg::SLOT_CMP_W'(req_glyph_slot)
                       < lmss_pkg::SLOT_CMP_W'(lmss_pkg::GLYPH_SLOTS);
   // even steps read the current slot, odd steps the next one
   assign rd_slot    = ctl.step[0] ? ({1'b0, text_slot_ff} + 1'b1) : {1'b0, text_slot_ff};
   assign rd_slot_ok = lmss_pkg::SLOT_CMP_W'(rd_slot)
                       < lmss_pkg::SLOT_CMP_W'(lmss_pkg::GLYPH_SLOTS);

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = lmss_pkg::RAM_ADDR_W'({req_glyph_slot, req_glyph_column});
      ram_wdata = req_glyph_bits;
      if (ctl.clear_en) begin
         ram_we    = 1'b1;
         ram_addr  = ctl.clear_addr;
         ram_wdata = '0;
      end else if (ctl.text_en) begin
         ram_addr = lmss_pkg::RAM_ADDR_W'({rd_slot, ctl.step[lmss_pkg::COL_W:1]});
      end else begin
         ram_we = accept && (req_func == lmss_pkg::FUNC_WRITE) && wr_slot_ok;
      end
   end

   lmss_ram #(
      .WIDTH (lmss_pkg::ROW_W),
      .DEPTH (lmss_pkg::RAM_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rd_val = blank_ff ? '0 : ram_rdata;

   // shared shifter operands
   always_comb begin
      if (display_mode_ff == lmss_pkg::MODE_UP) begin
         arrow_col = lmss_pkg::up_arrow(ctl.step[lmss_pkg::COL_W-1:0]);
      end else begin
         arrow_col = lmss_pkg::down_arrow(ctl.step[lmss_pkg::COL_W-1:0]);
      end
      if (ctl.text_en) begin
         sh_din    = {rd_val, a_ff};
         sh_amount = {1'b0, text_shift_ff};
      end else begin
         sh_din = {arrow_col, arrow_col};
         if (display_mode_ff == lmss_pkg::MODE_UP) begin
            sh_amount = {1'b0, up_shift_ff};
         end else begin
            // rotate left by s is a right funnel shift by 8 - s
            sh_amount = lmss_pkg::SHIFT_W'(lmss_pkg::ROW_W) - {1'b0, down_shift_ff};
         end
      end
   end

   lmss_shifter u_shift (
      .din    (sh_din),
      .amount (sh_amount),
      .dout   (sh_dout)
   );

   // column finished on an even step, one behind the pair of reads
   assign text_col  = lmss_pkg::COL_W'(ctl.step[lmss_pkg::STEP_W-1:1] - 1'b1);
   assign slot_inc  = {1'b0, text_slot_ff} + 1'b1;
   assign slot_wrap = (slot_inc > {1'b0, char_count_ff})
                      || (slot_inc > (lmss_pkg::SLOT_W+1)'(2**lmss_pkg::SLOT_W - 1));

   // result of the request in flight
   always_comb begin
      if (display_mode_ff == lmss_pkg::MODE_SMILE) begin
         rows_now = lmss_pkg::smile_face(scan_ff);
      end else begin
         rows_now = frame_ff[scan_ff];
      end
      drive_now = ~(lmss_pkg::ROW_W'(1) << scan_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff  <= lmss_pkg::MODE_TEXT;
         char_count_ff    <= lmss_pkg::RESET_CHAR_COUNT;
         scroll_period_ff <= lmss_pkg::RESET_PERIOD;
         tick_count_ff    <= '0;
         scan_ff          <= '0;
         text_shift_ff    <= '0;
         text_slot_ff     <= '0;
         up_shift_ff      <= '0;
         down_shift_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < lmss_pkg::MATRIX_SIZE; i++) begin
            frame_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lmss_pkg::CSR_DISPLAY_MODE:
                  display_mode_ff <= lmss_pkg::mode_type'(csr_data[lmss_pkg::MODE_W-1:0]);
               lmss_pkg::CSR_CHAR_COUNT:
                  char_count_ff <= csr_data[lmss_pkg::COUNT_W-1:0];
               lmss_pkg::CSR_SCROLL_PERIOD:
                  scroll_period_ff <= csr_data[lmss_pkg::PERIOD_W-1:0];
               default: ;
            endcase
         end

         if (accept && req_func == lmss_pkg::FUNC_TICK) begin
            tick_count_ff <= period_hit ? '0 : tick_sum;
         end

         if (ctl.text_en && ctl.step != '0 && !ctl.step[0]) begin
            frame_ff[text_col] <= sh_dout;
         end
         if (ctl.rot_en) begin
            frame_ff[ctl.step[lmss_pkg::COL_W-1:0]] <= sh_dout;
         end

         if (ctl.text_en && ctl.last) begin
            text_shift_ff <= text_shift_ff + 1'b1;
            if (text_shift_ff == '1) begin
               text_slot_ff <= slot_wrap ? '0 : slot_inc[lmss_pkg::SLOT_W-1:0];
            end
         end
         if (ctl.rot_en && ctl.last) begin
            if (display_mode_ff == lmss_pkg::MODE_UP) begin
               up_shift_ff <= up_shift_ff + 1'b1;
            end else begin
               down_shift_ff <= down_shift_ff + 1'b1;
            end
         end

         if (ctl.finish) begin
            rsp_valid_ff <= 1'b1;
            if (!is_write_ff) begin
               scan_ff <= scan_ff + 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         is_write_ff <= req_func;
         upd_ff      <= (req_func == lmss_pkg::FUNC_TICK) && do_update;
      end
      blank_ff <= !rd_slot_ok;
      if (ctl.text_en && ctl.step[0]) begin
         a_ff <= rd_val;
      end
      if (ctl.finish) begin
         if (is_write_ff) begin
            col_drive_ff <= '1;
            row_drive_ff <= '0;
            frame_upd_ff <= 1'b0;
         end else begin
            col_drive_ff <= drive_now;
            row_drive_ff <= rows_now;
            frame_upd_ff <= upd_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_drive  = col_drive_ff;
   assign rsp_row_drive     = row_drive_ff;
   assign rsp_frame_updated = frame_upd_ff;

   // no result may appear while the glyph store is still being cleared
   a_no_rsp_while_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clear_en |-> !rsp_valid)
      else $error("result valid during glyph store clearing");

   // at most one column is driven low
   a_one_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(~rsp_column_drive))
      else $error("more than one column driven");

   // a new result only comes from the final sequencer step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl.finish))
      else $error("result raised outside the finish step");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led matrix scroll scanner testbench
// Sends tick and glyph column write requests through random idle gaps and
// result stalls, predicts each scan result from a local copy of the frame,
// glyph store and counters, and checks every result against it. The register
// settings change between phases, once the block has drained.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [lmss_pkg::CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;

   // column i sits in byte i
   localparam logic [63:0] UP_ARROW_COLS   = 64'h1830_60E0_E060_3018;
   localparam logic [63:0] DOWN_ARROW_COLS = 64'h180C_0603_0306_0C18;
   localparam logic [63:0] SMILE_COLS      = 64'h0020_4422_2244_2000;

   typedef struct packed {
      logic       func;
      logic [5:0] slot;
      logic [2:0] column;
      logic [7:0] bits;
   } scan_req_type;

   typedef struct packed {
      logic [7:0] column_drive;
      logic [7:0] row_drive;
      logic       frame_updated;
   } scan_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid        = 1'b0;
   logic                            req_ready;
   logic                            req_func         = lmss_pkg::FUNC_TICK;
   logic [lmss_pkg::SLOT_W-1:0]     req_glyph_slot   = '0;
   logic [lmss_pkg::COL_W-1:0]      req_glyph_column = '0;
   logic [lmss_pkg::ROW_W-1:0]      req_glyph_bits   = '0;

   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [lmss_pkg::ROW_W-1:0]      rsp_column_drive;
   logic [lmss_pkg::ROW_W-1:0]      rsp_row_drive;
   logic                            rsp_frame_updated;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [lmss_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [lmss_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   led_matrix_scroll_scanner u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_glyph_slot    (req_glyph_slot),
      .req_glyph_column  (req_glyph_column),
      .req_glyph_bits    (req_glyph_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_column_drive  (rsp_column_drive),
      .rsp_row_drive     (rsp_row_drive),
      .rsp_frame_updated (rsp_frame_updated),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the display state
   logic [7:0]         glyph_mem [lmss_pkg::GLYPH_SLOTS*8];
   logic [7:0]         frame_col [8];
   logic [15:0]        tick_cnt;
   logic [2:0]         scan_col;
   logic [2:0]         txt_shift;
   logic [5:0]         txt_slot;
   logic [2:0]         up_rot;
   logic [2:0]         down_rot;
   lmss_pkg::mode_type cfg_mode;
   logic [5:0]         cfg_chars;
   logic [15:0]        cfg_period;

   scan_req_type scan_req_q[$];
   scan_out_type scan_expect_q[$];
   scan_req_type next_req;
   scan_out_type got_out;
   scan_out_type want_out;

   int  req_gap_left   = 0;
   int  rsp_stall_left = 0;
   bit  req_no_idle    = 1'b0;
   bit  rsp_no_idle    = 1'b0;
   int  mismatch_count = 0;
   int  result_count   = 0;

   function automatic int draw_wait(input bit no_idle);
      return no_idle ? 0 : int'($urandom_range(0, 16));
   endfunction

   function automatic scan_out_type predict_scan(input scan_req_type r);
      scan_out_type o;
      int           a;
      int           b;
      int           ts;
      int           nxt;
      logic [7:0]   pat;
      logic [15:0]  dbl;
      o.column_drive  = 8'hFF;
      o.row_drive     = 8'h00;
      o.frame_updated = 1'b0;
      if (r.func == lmss_pkg::FUNC_WRITE) begin
         glyph_mem[int'(r.slot) * 8 + int'(r.column)] = r.bits;
         return o;
      end
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= cfg_period) begin
         tick_cnt = '0;
         if (cfg_mode != lmss_pkg::MODE_SMILE) begin
            o.frame_updated = 1'b1;
            case (cfg_mode)
               lmss_pkg::MODE_TEXT: begin
                  ts = int'(txt_shift);
                  for (int i = 0; i < 8; i++) begin
                     a = int'(glyph_mem[int'(txt_slot) * 8 + i]);
                     // the slot past the end of the store reads blank
                     b = (int'(txt_slot) + 1 < lmss_pkg::GLYPH_SLOTS) ?
                         int'(glyph_mem[(int'(txt_slot) + 1) * 8 + i]) : 0;
                     frame_col[i] = 8'((a >> ts) | (b << (8 - ts)));
                  end
                  if (txt_shift == 3'd7) begin
                     txt_shift = 3'd0;
                     nxt = int'(txt_slot) + 1;
                     txt_slot = (nxt >= int'(cfg_chars) + 1 || nxt > 63) ? 6'd0 : 6'(nxt);
                  end else begin
                     txt_shift = txt_shift + 3'd1;
                  end
               end
               lmss_pkg::MODE_UP: begin
                  for (int i = 0; i < 8; i++) begin
                     pat = UP_ARROW_COLS[8*i +: 8];
                     dbl = {pat, pat} >> up_rot;
                     frame_col[i] = dbl[7:0];
                  end
                  up_rot = up_rot + 3'd1;
               end
               lmss_pkg::MODE_DOWN: begin
                  for (int i = 0; i < 8; i++) begin
                     pat = DOWN_ARROW_COLS[8*i +: 8];
                     dbl = {pat, pat} << down_rot;
                     frame_col[i] = dbl[15:8];
                  end
                  down_rot = down_rot + 3'd1;
               end
               default: ;
            endcase
         end
      end
      o.column_drive = ~(8'd1 << scan_col);
      o.row_drive = (cfg_mode == lmss_pkg::MODE_SMILE) ? SMILE_COLS[8*scan_col +: 8]
                                                       : frame_col[scan_col];
      scan_col = scan_col + 3'd1;
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left <= 0;
      end else begin
         if (req_valid && req_ready)
            scan_expect_q.push_back(predict_scan({req_func, req_glyph_slot,
                                                  req_glyph_column, req_glyph_bits}));
         if (!req_valid || req_ready) begin
            if (req_gap_left != 0) begin
               req_valid    <= 1'b0;
               req_gap_left <= req_gap_left - 1;
            end else if (scan_req_q.size() != 0) begin
               next_req = scan_req_q.pop_front();
               req_valid        <= 1'b1;
               req_func         <= next_req.func;
               req_glyph_slot   <= next_req.slot;
               req_glyph_column <= next_req.column;
               req_glyph_bits   <= next_req.bits;
               if ($urandom_range(0, 39) == 0)
                  req_no_idle = !req_no_idle;
               req_gap_left <= draw_wait(req_no_idle);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_out = {rsp_column_drive, rsp_row_drive, rsp_frame_updated};
            result_count++;
            if (scan_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d with no request pending: col %h row %h upd %b",
                           result_count, got_out.column_drive, got_out.row_drive,
                           got_out.frame_updated);
            end else begin
               want_out = scan_expect_q.pop_front();
               if (got_out.column_drive !== want_out.column_drive ||
                   got_out.row_drive !== want_out.row_drive ||
                   got_out.frame_updated !== want_out.frame_updated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d mismatch: exp %h %h %b, got %h %h %b",
                              result_count, want_out.column_drive, want_out.row_drive,
                              want_out.frame_updated, got_out.column_drive,
                              got_out.row_drive, got_out.frame_updated);
               end
            end
            if ($urandom_range(0, 39) == 0)
               rsp_no_idle = !rsp_no_idle;
            rsp_stall_left = draw_wait(rsp_no_idle);
            if (rsp_stall_left != 0)
               rsp_ready <= 1'b0;
         end else if (!rsp_ready) begin
            if (rsp_stall_left <= 1)
               rsp_ready <= 1'b1;
            else
               rsp_stall_left = rsp_stall_left - 1;
         end
      end
   end

   task automatic push_req(input logic func, input logic [5:0] slot,
                           input logic [2:0] column, input logic [7:0] bits);
      scan_req_q.push_back({func, slot, column, bits});
   endtask

   task automatic push_tick();
      push_req(lmss_pkg::FUNC_TICK, 6'($urandom), 3'($urandom), 8'($urandom));
   endtask

   task automatic csr_write(input logic [lmss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         lmss_pkg::CSR_DISPLAY_MODE:  cfg_mode   = lmss_pkg::mode_type'(data[1:0]);
         lmss_pkg::CSR_CHAR_COUNT:    cfg_chars  = data[5:0];
         lmss_pkg::CSR_SCROLL_PERIOD: cfg_period = data;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (scan_req_q.size() != 0 || req_valid || scan_expect_q.size() != 0)
         @(posedge clock);
   endtask

   // random mix of ticks and glyph writes, mostly into the low slots
   task automatic push_mixed(input int count, input int write_pct);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < write_pct)
            push_req(lmss_pkg::FUNC_WRITE,
                     ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 9)) : 6'($urandom),
                     3'($urandom), 8'($urandom));
         else
            push_tick();
      end
   endtask

   initial begin
      int sent;
      int n;
      int r;
      logic [15:0] upper;
      for (int i = 0; i < lmss_pkg::GLYPH_SLOTS * 8; i++)
         glyph_mem[i] = 8'h00;
      for (int i = 0; i < 8; i++)
         frame_col[i] = 8'h00;
      tick_cnt   = '0;
      scan_col   = '0;
      txt_shift  = '0;
      txt_slot   = '0;
      up_rot     = '0;
      down_rot   = '0;
      cfg_mode   = lmss_pkg::MODE_TEXT;
      cfg_chars  = 6'd5;
      cfg_period = 16'd500;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: field extremes, frame still blank
      @(negedge clock);
      push_req(lmss_pkg::FUNC_WRITE, 6'd0, 3'd0, 8'hFF);
      push_req(lmss_pkg::FUNC_WRITE, 6'd63, 3'd7, 8'h00);
      push_req(lmss_pkg::FUNC_WRITE, 6'd63, 3'd0, 8'h3C);
      push_req(lmss_pkg::FUNC_WRITE, 6'd1, 3'd0, 8'h81);
      push_req(lmss_pkg::FUNC_WRITE, 6'd2, 3'd7, 8'hC3);
      push_tick();
      push_tick();
      wait_drained();

      // zero period updates on every tick; upper data bits are dropped
      csr_write(lmss_pkg::CSR_SCROLL_PERIOD, 16'h0000);
      csr_write(lmss_pkg::CSR_CHAR_COUNT, 16'hFFFF);
      @(negedge clock);
      repeat (4) push_tick();
      wait_drained();

      csr_write(lmss_pkg::CSR_DISPLAY_MODE, 16'hFFFD);
      @(negedge clock);
      repeat (3) push_tick();
      wait_drained();

      csr_write(lmss_pkg::CSR_DISPLAY_MODE, 16'(lmss_pkg::MODE_DOWN));
      @(negedge clock);
      repeat (3) push_tick();
      wait_drained();

      csr_write(lmss_pkg::CSR_DISPLAY_MODE, 16'(lmss_pkg::MODE_SMILE));
      @(negedge clock);
      repeat (2) push_tick();
      wait_drained();

      // spare index is ignored; long period keeps the counter running
      csr_write(CSR_SPARE_IDX, 16'hFFFF);
      csr_write(lmss_pkg::CSR_SCROLL_PERIOD, 16'hFFFF);
      @(negedge clock);
      push_tick();
      wait_drained();

      // full text sweep to the last slot and past the end of the store
      csr_write(lmss_pkg::CSR_DISPLAY_MODE, 16'(lmss_pkg::MODE_TEXT));
      csr_write(lmss_pkg::CSR_SCROLL_PERIOD, 16'h0000);
      csr_write(lmss_pkg::CSR_CHAR_COUNT, 16'd63);
      @(negedge clock);
      push_mixed(640, 15);
      sent = 640;
      wait_drained();

      // empty text and period of one
      csr_write(lmss_pkg::CSR_CHAR_COUNT, 16'hFFC0);
      csr_write(lmss_pkg::CSR_SCROLL_PERIOD, 16'd1);
      @(negedge clock);
      push_mixed(40, 20);
      sent += 40;
      wait_drained();

      while (sent < 1350) begin
         upper = 16'($urandom);
         if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 5);
            csr_write(lmss_pkg::CSR_DISPLAY_MODE,
                      (upper & 16'hFFFC) |
                      ((r < 3) ? 16'(lmss_pkg::MODE_TEXT) : 16'(r - 2)));
         end
         if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 9);
            n = (r == 0) ? 0 : (r == 1) ? 62 : (r == 2) ? 63 : $urandom_range(1, 8);
            csr_write(lmss_pkg::CSR_CHAR_COUNT, (upper & 16'hFFC0) | 16'(n));
         end
         if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 19);
            n = (r == 0) ? 65535 : (r == 1) ? 500 : (r == 2) ? $urandom_range(5, 40) :
                $urandom_range(0, 3);
            csr_write(lmss_pkg::CSR_SCROLL_PERIOD, 16'(n));
         end
         if ($urandom_range(0, 9) == 0)
            csr_write(CSR_SPARE_IDX, 16'($urandom));
         n = $urandom_range(15, 60);
         @(negedge clock);
         push_mixed(n, 25);
         sent += n;
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && scan_expect_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
hdl/lmss_pkg.sv
hdl/lmss_ram.sv
hdl/lmss_shifter.sv
hdl/lmss_sequencer.sv
hdl/led_matrix_scroll_scanner.sv
bench/testbench.sv
